// File: hdl/eat_pkg.sv
// ----------------------------------------------------------------------------
// Ellipse arc tracer package
// Shared constants, datapath command codes and the control/status bundles.
// ----------------------------------------------------------------------------
package eat_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int AXIS_BITS_DEF  = 12;

  // Meaning of the action bit of an input word.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Operand pairs that the shared setup multiplier can be given.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AA,
    MUL_BB,
    MUL_XX,
    MUL_YY,
    MUL_BX2,
    MUL_AY2,
    MUL_AB,
    MUL_BKX,
    MUL_AKY
  } mul_op_t;

  // Where the registered product goes in the cycle after it was issued.
  typedef enum logic [3:0] {
    CAP_NONE,
    CAP_A2,
    CAP_B2,
    CAP_X2,
    CAP_Y2,
    CAP_ERR_SET,
    CAP_ERR_ADD,
    CAP_ERR_SUB,
    CAP_INC_X,
    CAP_INC_Y
  } cap_op_t;

  typedef struct packed {
    logic    load;
    logic    step;
    mul_op_t mul;
    cap_op_t cap;
  } eat_cmd_t;

  typedef struct packed {
    logic finish;
  } eat_sts_t;

endpackage

// File: hdl/eat_if.sv
// ----------------------------------------------------------------------------
// Ellipse arc tracer channels
// Valid/ready channel bundles for the trace request and the pixel result.
// ----------------------------------------------------------------------------
interface eat_in_if import eat_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [AXIS_BITS-1:0]  half_axis_x;
  logic        [AXIS_BITS-1:0]  half_axis_y;
  logic signed [AXIS_BITS:0]    from_x;
  logic signed [AXIS_BITS:0]    from_y;
  logic signed [AXIS_BITS:0]    to_x;
  logic signed [AXIS_BITS:0]    to_y;

  modport source (
    output valid, action, center_x, center_y, half_axis_x, half_axis_y,
           from_x, from_y, to_x, to_y,
    input  ready
  );
  modport sink (
    input  valid, action, center_x, center_y, half_axis_x, half_axis_y,
           from_x, from_y, to_x, to_y,
    output ready
  );
endinterface

interface eat_out_if import eat_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, last_pixel,
    output ready
  );
endinterface

// File: hdl/eat_ctrl.sv
// ----------------------------------------------------------------------------
// Ellipse arc tracer controller
// Sequences the setup multiplies, gates the input and owns the output valid.
// ----------------------------------------------------------------------------
module eat_ctrl import eat_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output eat_cmd_t cmd,
  input  eat_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AA,
    S_MUL_BB,
    S_MUL_XX,
    S_MUL_YY,
    S_MUL_BX2,
    S_MUL_AY2,
    S_MUL_AB,
    S_MUL_BKX,
    S_MUL_AKY,
    S_CAP_INC_Y,
    S_TRACE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = ((state_r == S_IDLE) || (state_r == S_TRACE)) &&
                     (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load = accept && (in_action == ACT_START);
    cmd.step = accept && (in_action == ACT_STEP) && (state_r == S_TRACE);
    cmd.mul  = MUL_NONE;
    cmd.cap  = CAP_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_MUL_AA;
      end
      S_MUL_AA: begin
        cmd.mul   = MUL_AA;
        state_nxt = S_MUL_BB;
      end
      S_MUL_BB: begin
        cmd.mul   = MUL_BB;
        cmd.cap   = CAP_A2;
        state_nxt = S_MUL_XX;
      end
      S_MUL_XX: begin
        cmd.mul   = MUL_XX;
        cmd.cap   = CAP_B2;
        state_nxt = S_MUL_YY;
      end
      S_MUL_YY: begin
        cmd.mul   = MUL_YY;
        cmd.cap   = CAP_X2;
        state_nxt = S_MUL_BX2;
      end
      S_MUL_BX2: begin
        cmd.mul   = MUL_BX2;
        cmd.cap   = CAP_Y2;
        state_nxt = S_MUL_AY2;
      end
      S_MUL_AY2: begin
        cmd.mul   = MUL_AY2;
        cmd.cap   = CAP_ERR_SET;
        state_nxt = S_MUL_AB;
      end
      S_MUL_AB: begin
        cmd.mul   = MUL_AB;
        cmd.cap   = CAP_ERR_ADD;
        state_nxt = S_MUL_BKX;
      end
      S_MUL_BKX: begin
        cmd.mul   = MUL_BKX;
        cmd.cap   = CAP_ERR_SUB;
        state_nxt = S_MUL_AKY;
      end
      S_MUL_AKY: begin
        cmd.mul   = MUL_AKY;
        cmd.cap   = CAP_INC_X;
        state_nxt = S_CAP_INC_Y;
      end
      S_CAP_INC_Y: begin
        cmd.cap   = CAP_INC_Y;
        state_nxt = S_TRACE;
      end
      S_TRACE: begin
        if (cmd.load) begin
          state_nxt = S_MUL_AA;
        end else if (cmd.step && sts.finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/eat_dp.sv
// ----------------------------------------------------------------------------
// Ellipse arc tracer datapath
// Trace state, the shared setup multiplier, the step logic and the pixel
// output register.
// ----------------------------------------------------------------------------
module eat_dp import eat_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF
) (
  input  logic                         clk,
  input  eat_cmd_t                     cmd,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic        [AXIS_BITS-1:0]  half_axis_x,
  input  logic        [AXIS_BITS-1:0]  half_axis_y,
  input  logic signed [AXIS_BITS:0]    from_x,
  input  logic signed [AXIS_BITS:0]    from_y,
  input  logic signed [AXIS_BITS:0]    to_x,
  input  logic signed [AXIS_BITS:0]    to_y,
  output eat_sts_t                     sts,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel
);

  localparam int PW   = AXIS_BITS + 1;       // point coordinates
  localparam int EW   = 4 * AXIS_BITS + 2;   // error term
  localparam int IW   = 3 * AXIS_BITS + 4;   // error increments
  localparam int SQW  = 2 * AXIS_BITS;       // squared half-axes
  localparam int MBW  = 2 * AXIS_BITS + 2;   // signed multiplier operand
  localparam int SUMW = EW + 2;              // exact trial error sums
  localparam int KW   = PW + 2;              // 2*dir*p + 1
  localparam int ZW   = PW + 1;              // unwrapped run probe

  logic        [COORD_BITS-1:0] origin_x_r, origin_x_nxt, origin_y_r, origin_y_nxt;
  logic        [AXIS_BITS-1:0]  axis_r, axis_nxt, b_r, b_nxt;
  logic signed [PW-1:0]         cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [PW-1:0]         end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  logic signed [PW-1:0]         run_pos_r, run_pos_nxt;
  logic                         neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic                         in_run_r, in_run_nxt;
  logic signed [EW-1:0]         err_r, err_nxt, prod_r, prod_nxt;
  logic signed [IW-1:0]         inc_x_r, inc_x_nxt, inc_y_r, inc_y_nxt;
  logic        [SQW-1:0]        a2_r, a2_nxt, b2_r, b2_nxt;
  logic        [COORD_BITS-1:0] pix_x_r, pix_x_nxt, pix_y_r, pix_y_nxt;
  logic                         last_r, last_nxt;

  // Setup multiplier operands.
  logic        [PW-1:0]  mag_x, mag_y;
  logic signed [KW-1:0]  twox, twoy, kx, ky;
  logic        [SQW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [EW:0]    prod_full;

  // Step evaluation.
  logic signed [SUMW-1:0] e_s, dx_s, dy_s, s_x, s_y, s_xy;
  logic        [SUMW-1:0] ax, ay, axy;
  logic                   mv_x, mv_y;
  logic signed [EW-1:0]   e1;
  logic signed [IW-1:0]   twa_i, twb_i, dx_up, dy_up, dx_flip, dy_flip;
  logic signed [PW-1:0]   dxu, dyu, cx1, cy1;
  logic signed [ZW-1:0]   z_s, zr_s;
  logic        [ZW-1:0]   abs_z, abs_zr;
  logic                   fits, fits_r, done1, done_cur, run_start;
  logic                   x_pos, x_zero, y_pos, y_zero;
  logic        [COORD_BITS-1:0] px_c, py_c;

  assign mag_x = cur_x_r[PW-1] ? PW'(-cur_x_r) : PW'(cur_x_r);
  assign mag_y = cur_y_r[PW-1] ? PW'(-cur_y_r) : PW'(cur_y_r);
  assign twox  = $signed({cur_x_r[PW-1], cur_x_r, 1'b0});
  assign twoy  = $signed({cur_y_r[PW-1], cur_y_r, 1'b0});
  assign kx    = neg_x_r ? (-twox + KW'(1)) : (twox + KW'(1));
  assign ky    = neg_y_r ? (-twoy + KW'(1)) : (twoy + KW'(1));

  always_comb begin
    unique case (cmd.mul)
      MUL_AA: begin
        mul_a = SQW'(axis_r);
        mul_b = MBW'(axis_r);
      end
      MUL_BB: begin
        mul_a = SQW'(b_r);
        mul_b = MBW'(b_r);
      end
      MUL_XX: begin
        mul_a = SQW'(mag_x);
        mul_b = MBW'(mag_x);
      end
      MUL_YY: begin
        mul_a = SQW'(mag_y);
        mul_b = MBW'(mag_y);
      end
      MUL_BX2: begin
        mul_a = b2_r;
        mul_b = MBW'(inc_x_r[2*AXIS_BITS:0]);
      end
      MUL_AY2: begin
        mul_a = a2_r;
        mul_b = MBW'(inc_y_r[2*AXIS_BITS:0]);
      end
      MUL_AB: begin
        mul_a = a2_r;
        mul_b = MBW'(b2_r);
      end
      MUL_BKX: begin
        mul_a = b2_r;
        mul_b = MBW'(kx);
      end
      MUL_AKY: begin
        mul_a = a2_r;
        mul_b = MBW'(ky);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = $signed({1'b0, mul_a}) * mul_b;
  assign prod_nxt  = $signed(prod_full[EW-1:0]);

  // Trial errors for a move in y, in x and in both, kept exact.
  assign e_s  = SUMW'(err_r);
  assign dx_s = SUMW'(inc_x_r);
  assign dy_s = SUMW'(inc_y_r);
  assign s_x  = e_s + dx_s;
  assign s_y  = e_s + dy_s;
  assign s_xy = s_x + dy_s;
  assign ax   = s_x[SUMW-1]  ? SUMW'(-s_x)  : SUMW'(s_x);
  assign ay   = s_y[SUMW-1]  ? SUMW'(-s_y)  : SUMW'(s_y);
  assign axy  = s_xy[SUMW-1] ? SUMW'(-s_xy) : SUMW'(s_xy);
  assign mv_y = (axy <= ax) || (ay < ax);
  assign mv_x = (axy <= ay) || (ax < ay);

  always_comb begin
    unique case ({mv_y, mv_x})
      2'b00:   e1 = err_r;
      2'b01:   e1 = $signed(s_x[EW-1:0]);
      2'b10:   e1 = $signed(s_y[EW-1:0]);
      default: e1 = $signed(s_xy[EW-1:0]);
    endcase
  end

  // Increment updates; a direction flip negates the increment, which after
  // a move in the same axis collapses to a plain negation.
  assign twa_i   = IW'({a2_r, 1'b0});
  assign twb_i   = IW'({b2_r, 1'b0});
  assign dx_up   = inc_x_r + twb_i;
  assign dy_up   = inc_y_r + twa_i;
  assign dx_flip = mv_x ? -inc_x_r : (twb_i - inc_x_r);
  assign dy_flip = mv_y ? -inc_y_r : (twa_i - inc_y_r);

  assign dxu = neg_x_r ? '1 : PW'(1);
  assign dyu = neg_y_r ? '1 : PW'(1);
  assign cx1 = mv_x ? (cur_x_r + dxu) : cur_x_r;
  assign cy1 = mv_y ? (cur_y_r + dyu) : cur_y_r;

  assign z_s    = ZW'(cx1) + ZW'(dxu);
  assign abs_z  = z_s[ZW-1] ? ZW'(-z_s) : ZW'(z_s);
  assign fits   = abs_z <= ZW'(axis_r);
  assign zr_s   = ZW'(run_pos_r) - ZW'(dxu);
  assign abs_zr = zr_s[ZW-1] ? ZW'(-zr_s) : ZW'(zr_s);
  assign fits_r = abs_zr <= ZW'(axis_r);

  assign done1     = (cx1 == end_x_r) && (cy1 == end_y_r);
  assign done_cur  = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
  assign run_start = (cx1 != '0) && (cy1 == '0) && fits;

  assign sts.finish = in_run_r ? (!fits_r && done_cur) : (!run_start && done1);

  assign x_pos  = !from_x[PW-1] && (from_x != '0);
  assign x_zero = (from_x == '0);
  assign y_pos  = !from_y[PW-1] && (from_y != '0);
  assign y_zero = (from_y == '0);

  assign px_c = in_run_r ? COORD_BITS'(run_pos_r) : COORD_BITS'(cx1);
  assign py_c = in_run_r ? COORD_BITS'(cur_y_r)   : COORD_BITS'(cy1);

  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    axis_nxt     = axis_r;
    b_nxt        = b_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    end_x_nxt    = end_x_r;
    end_y_nxt    = end_y_r;
    run_pos_nxt  = run_pos_r;
    neg_x_nxt    = neg_x_r;
    neg_y_nxt    = neg_y_r;
    in_run_nxt   = in_run_r;
    err_nxt      = err_r;
    inc_x_nxt    = inc_x_r;
    inc_y_nxt    = inc_y_r;
    a2_nxt       = a2_r;
    b2_nxt       = b2_r;
    pix_x_nxt    = pix_x_r;
    pix_y_nxt    = pix_y_r;
    last_nxt     = last_r;

    if (cmd.load) begin
      origin_x_nxt = center_x;
      origin_y_nxt = center_y;
      axis_nxt     = half_axis_x;
      b_nxt        = half_axis_y;
      cur_x_nxt    = from_x;
      cur_y_nxt    = from_y;
      end_x_nxt    = to_x;
      end_y_nxt    = to_y;
      neg_x_nxt    = from_y[PW-1] || (y_zero && x_pos);
      neg_y_nxt    = x_pos || (x_zero && y_pos);
      in_run_nxt   = 1'b0;
      run_pos_nxt  = '0;
    end

    unique case (cmd.cap)
      CAP_A2:      a2_nxt    = prod_r[SQW-1:0];
      CAP_B2:      b2_nxt    = prod_r[SQW-1:0];
      CAP_X2:      inc_x_nxt = $signed(prod_r[IW-1:0]);
      CAP_Y2:      inc_y_nxt = $signed(prod_r[IW-1:0]);
      CAP_ERR_SET: err_nxt   = prod_r;
      CAP_ERR_ADD: err_nxt   = err_r + prod_r;
      CAP_ERR_SUB: err_nxt   = err_r - prod_r;
      CAP_INC_X:   inc_x_nxt = $signed(prod_r[IW-1:0]);
      CAP_INC_Y:   inc_y_nxt = $signed(prod_r[IW-1:0]);
      default: ;
    endcase

    if (cmd.step) begin
      pix_x_nxt = origin_x_r + px_c;
      pix_y_nxt = origin_y_r + py_c;
      last_nxt  = sts.finish;
      if (in_run_r) begin
        // Horizontal run along y = 0 toward the half-axis.
        if (fits_r) begin
          run_pos_nxt = zr_s[PW-1:0];
        end else begin
          in_run_nxt = 1'b0;
        end
      end else begin
        cur_x_nxt = cx1;
        cur_y_nxt = cy1;
        err_nxt   = e1;
        inc_x_nxt = mv_x ? dx_up : inc_x_r;
        inc_y_nxt = mv_y ? dy_up : inc_y_r;
        if (cx1 == '0) begin
          neg_y_nxt = !neg_y_r;
          inc_y_nxt = dy_flip;
        end else if (cy1 == '0) begin
          if (fits) begin
            in_run_nxt  = 1'b1;
            run_pos_nxt = z_s[PW-1:0];
          end
          neg_x_nxt = !neg_x_r;
          inc_x_nxt = dx_flip;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    origin_x_r <= origin_x_nxt;
    origin_y_r <= origin_y_nxt;
    axis_r     <= axis_nxt;
    b_r        <= b_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    end_x_r    <= end_x_nxt;
    end_y_r    <= end_y_nxt;
    run_pos_r  <= run_pos_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    in_run_r   <= in_run_nxt;
    err_r      <= err_nxt;
    inc_x_r    <= inc_x_nxt;
    inc_y_r    <= inc_y_nxt;
    a2_r       <= a2_nxt;
    b2_r       <= b2_nxt;
    prod_r     <= prod_nxt;
    pix_x_r    <= pix_x_nxt;
    pix_y_r    <= pix_y_nxt;
    last_r     <= last_nxt;
  end

  assign pixel_x    = pix_x_r;
  assign pixel_y    = pix_y_r;
  assign last_pixel = last_r;

endmodule

// File: hdl/ellipse_arc_tracer_top.sv
// ----------------------------------------------------------------------------
// Ellipse arc tracer
// Clockwise incremental tracer for an ellipse or elliptic arc, one pixel
// per step word.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake      Word
//   in_ch    in   valid/ready    action, center, half-axes, start and end
//   out_ch   out  valid/ready    pixel_x, pixel_y, last_pixel
//
// A start word is followed by the setup sequence with in_ch.ready low, in which
// one shared multiplier builds b^2*x^2 + a^2*y^2 - a^2*b^2 and both increments.
// After that a step word is taken every cycle and its pixel is valid in the
// next one; the wide trial adds and compares of the error update set the clock.
// Outside setup, in_ch.ready drops only while the output register holds a pixel
// that out_ch does not take. Synchronous active-low reset returns to idle.
//
module ellipse_arc_tracer_top import eat_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AXIS_BITS  = AXIS_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  eat_in_if.sink    in_ch,
  eat_out_if.source out_ch
);

  eat_cmd_t cmd;
  eat_sts_t sts;

  // The controller decides when a word is taken and what the datapath does
  // in each cycle; it also owns the valid flag of the pixel register.
  eat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the geometry, the error terms and the pixel payload.
  eat_dp #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .center_x    (in_ch.center_x),
    .center_y    (in_ch.center_y),
    .half_axis_x (in_ch.half_axis_x),
    .half_axis_y (in_ch.half_axis_y),
    .from_x      (in_ch.from_x),
    .from_y      (in_ch.from_y),
    .to_x        (in_ch.to_x),
    .to_y        (in_ch.to_y),
    .sts         (sts),
    .pixel_x     (out_ch.pixel_x),
    .pixel_y     (out_ch.pixel_y),
    .last_pixel  (out_ch.last_pixel)
  );

  // A start word always leads into the setup sequence, which blocks input.
  a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.action == ACT_START)) |=> !in_ch.ready)
    else $error("input taken right after a start word");

  // Every executed step leaves a pixel in the output register.
  a_step_gives_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_ch.valid)
    else $error("step executed without a pixel");

  // A pixel only appears as the result of a step.
  a_pixel_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.step))
    else $error("pixel valid without a step");

endmodule
